// ===== hdl/sism_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and setpoint masking for the inverter startup/setpoint manager.
// No dependencies.
package sism_pkg;

    localparam int MOTORS_DEF      = 4;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam int MOTOR_W = 2;
    localparam int SP_W    = 16;
    localparam int CTL_W   = 4;
    localparam int MODE_W  = 3;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DRIVING_MODE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MOTOR_ENABLE = 1'b1;

    // command opcodes
    localparam logic OP_STATUS  = 1'b0;
    localparam logic OP_COMMAND = 1'b1;

    // control nibble bits
    localparam logic [CTL_W-1:0] CTL_ERR_RESET = 4'b1000;
    localparam logic [CTL_W-1:0] CTL_ENABLE    = 4'b0100;
    localparam logic [CTL_W-1:0] CTL_DC_ON     = 4'b0010;
    localparam logic [CTL_W-1:0] CTL_INV_ON    = 4'b0001;

    // stored status bit positions
    localparam int ST_READY   = 0;
    localparam int ST_ERROR   = 1;
    localparam int ST_DC_ACK  = 2;
    localparam int ST_INV_ACK = 3;

    // status byte bit positions
    localparam int SB_READY   = 0;
    localparam int SB_ERROR   = 1;
    localparam int SB_DC_ACK  = 3;
    localparam int SB_INV_ACK = 5;

    // driving modes
    localparam logic [MODE_W-1:0] MODE_FORWARD   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_COAST     = 3'd1;
    localparam logic [MODE_W-1:0] MODE_BRAKE_POS = 3'd2;
    localparam logic [MODE_W-1:0] MODE_BRAKE_NEG = 3'd3;
    localparam logic [MODE_W-1:0] MODE_REVERSE   = 3'd4;

    typedef enum logic [1:0] {
        BR_INIT     = 2'd0,
        BR_ERROR    = 2'd1,
        BR_RUN      = 2'd2,
        BR_SHUTDOWN = 2'd3
    } t_branch;

    typedef struct packed {
        logic signed [SP_W-1:0] vel;
        logic signed [SP_W-1:0] pos;
        logic signed [SP_W-1:0] neg;
    } t_setpoints;

    // one queued command: one or two frames for one motor
    typedef struct packed {
        logic [MOTOR_W-1:0] motor;
        logic [CTL_W-1:0]   ctl_a;
        logic [CTL_W-1:0]   ctl_b;
        t_setpoints         sp;
        logic               two;
    } t_cmd;

    function automatic t_setpoints apply_setpoints(
        input logic [MODE_W-1:0] mode,
        input t_setpoints        req,
        input t_setpoints        old
    );
        t_setpoints r;
        r = old;
        case (mode)
            MODE_FORWARD, MODE_REVERSE: r = req;
            MODE_COAST: begin
                r.vel = req.vel;
                r.pos = '0;
                r.neg = '0;
            end
            MODE_BRAKE_POS: begin
                r.vel = '0;
                r.pos = '0;
                r.neg = req.neg;
            end
            MODE_BRAKE_NEG: begin
                r.vel = '0;
                r.pos = req.pos;
                r.neg = '0;
            end
            default: r = old;
        endcase
        return r;
    endfunction

endpackage

// ===== hdl/sism_in_if.sv =====
`timescale 1ns / 1ps
// Input channel: status frames and setpoint commands.
// Depends on sism_pkg.
interface sism_in_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  opcode;
    logic [sism_pkg::MOTOR_W-1:0]          motor;
    logic [7:0]                            status_byte;
    logic signed [sism_pkg::SP_W-1:0]      velocity_ref;
    logic signed [sism_pkg::SP_W-1:0]      pos_torque;
    logic signed [sism_pkg::SP_W-1:0]      neg_torque;

    modport source (output valid, opcode, motor, status_byte, velocity_ref, pos_torque,
                    neg_torque, input ready);
    modport sink   (input valid, opcode, motor, status_byte, velocity_ref, pos_torque,
                    neg_torque, output ready);
endinterface

// ===== hdl/sism_out_if.sv =====
`timescale 1ns / 1ps
// Output channel: setpoint frames.
// Depends on sism_pkg.
interface sism_out_if;
    logic                                  valid;
    logic                                  ready;
    logic [sism_pkg::MOTOR_W-1:0]          out_motor;
    logic [sism_pkg::CTL_W-1:0]            control_bits;
    logic signed [sism_pkg::SP_W-1:0]      target_velocity;
    logic signed [sism_pkg::SP_W-1:0]      torque_limit_pos;
    logic signed [sism_pkg::SP_W-1:0]      torque_limit_neg;
    logic                                  last;

    modport source (output valid, out_motor, control_bits, target_velocity, torque_limit_pos,
                    torque_limit_neg, last, input ready);
    modport sink   (input valid, out_motor, control_bits, target_velocity, torque_limit_pos,
                    torque_limit_neg, last, output ready);
endinterface

// ===== hdl/sism_front.sv =====
`timescale 1ns / 1ps
// Front end: takes items, keeps per-motor state and config, classifies commands
// and pushes frame descriptors to the queue. Depends on sism_pkg, sism_in_if.
module sism_front #(
    parameter int MOTORS = sism_pkg::MOTORS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    sism_in_if.sink                         i_cmd,
    input  logic                            i_cfg_we,
    input  logic [sism_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [sism_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_full,
    output logic                            o_push,
    output sism_pkg::t_cmd                  o_cmd
);

    localparam int SEL_W = 5;

    logic [sism_pkg::MODE_W-1:0] r_mode;
    logic                        r_enable;

    logic [3:0]                  r_status  [MOTORS];
    logic [sism_pkg::CTL_W-1:0]  r_ctl     [MOTORS];
    logic [MOTORS-1:0]           r_init;
    sism_pkg::t_setpoints        r_sp      [MOTORS];

    logic                        accept;
    logic [MOTORS-1:0]           sel;
    logic [3:0]                  cur_st;
    logic [sism_pkg::CTL_W-1:0]  cur_ctl;
    logic                        cur_init;
    sism_pkg::t_setpoints        cur_sp;
    sism_pkg::t_setpoints        req_sp;
    sism_pkg::t_setpoints        new_sp;
    logic [sism_pkg::CTL_W-1:0]  new_ctl;
    logic                        new_init;
    logic [3:0]                  dec_st;
    sism_pkg::t_branch           branch;

    assign i_cmd.ready = ~i_full;
    assign accept      = i_cmd.valid & ~i_full;

    // one-hot motor decode; motors at or beyond MOTORS select nothing
    always_comb begin
        for (int i = 0; i < MOTORS; i++) begin
            sel[i] = ({3'b000, i_cmd.motor} == SEL_W'(i));
        end
    end

    always_comb begin
        cur_st   = '0;
        cur_ctl  = '0;
        cur_init = 1'b0;
        cur_sp   = '0;
        for (int i = 0; i < MOTORS; i++) begin
            if (sel[i]) begin
                cur_st   = r_status[i];
                cur_ctl  = r_ctl[i];
                cur_init = r_init[i];
                cur_sp   = r_sp[i];
            end
        end
    end

    assign dec_st = {i_cmd.status_byte[sism_pkg::SB_INV_ACK],
                     i_cmd.status_byte[sism_pkg::SB_DC_ACK],
                     i_cmd.status_byte[sism_pkg::SB_ERROR],
                     i_cmd.status_byte[sism_pkg::SB_READY]};

    always_comb begin
        if (!cur_init && cur_st[sism_pkg::ST_READY]) begin
            branch = sism_pkg::BR_INIT;
        end else if (cur_st[sism_pkg::ST_ERROR]) begin
            branch = sism_pkg::BR_ERROR;
        end else if (cur_init && cur_st[sism_pkg::ST_INV_ACK]) begin
            branch = sism_pkg::BR_RUN;
        end else begin
            branch = sism_pkg::BR_SHUTDOWN;
        end
    end

    always_comb begin
        req_sp   = '0;
        new_ctl  = cur_ctl;
        new_init = cur_init;
        o_cmd.ctl_a = cur_ctl;
        o_cmd.two   = 1'b0;
        case (branch)
            sism_pkg::BR_INIT: begin
                new_ctl = sism_pkg::CTL_DC_ON;
                if (cur_st[sism_pkg::ST_DC_ACK] && r_enable) begin
                    new_ctl = new_ctl | sism_pkg::CTL_ENABLE | sism_pkg::CTL_INV_ON;
                end
                new_init    = cur_st[sism_pkg::ST_READY] & cur_st[sism_pkg::ST_DC_ACK]
                            & cur_st[sism_pkg::ST_INV_ACK];
                o_cmd.ctl_a = new_ctl;
            end
            sism_pkg::BR_ERROR: begin
                // first frame carries the old control bits, second the error reset
                new_ctl   = (cur_ctl & ~(sism_pkg::CTL_INV_ON | sism_pkg::CTL_ENABLE))
                          | sism_pkg::CTL_ERR_RESET;
                new_init  = 1'b0;
                o_cmd.two = 1'b1;
            end
            sism_pkg::BR_RUN: begin
                req_sp.vel = i_cmd.velocity_ref;
                req_sp.pos = i_cmd.pos_torque;
                req_sp.neg = i_cmd.neg_torque;
            end
            sism_pkg::BR_SHUTDOWN: begin
                new_ctl     = '0;
                new_init    = 1'b0;
                o_cmd.ctl_a = '0;
            end
            default: begin
                new_ctl = cur_ctl;
            end
        endcase
        new_sp      = sism_pkg::apply_setpoints(r_mode, req_sp, cur_sp);
        o_cmd.ctl_b = new_ctl;
        o_cmd.sp    = new_sp;
        o_cmd.motor = i_cmd.motor;
    end

    assign o_push = accept & (i_cmd.opcode == sism_pkg::OP_COMMAND) & (|sel);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= '0;
            r_enable <= 1'b0;
            r_init   <= '0;
            for (int i = 0; i < MOTORS; i++) begin
                r_status[i] <= '0;
                r_ctl[i]    <= '0;
                r_sp[i]     <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    sism_pkg::CFG_DRIVING_MODE: r_mode   <= i_cfg_data;
                    sism_pkg::CFG_MOTOR_ENABLE: r_enable <= i_cfg_data[0];
                    default: r_mode <= r_mode;
                endcase
            end
            for (int i = 0; i < MOTORS; i++) begin
                if (accept && sel[i]) begin
                    if (i_cmd.opcode == sism_pkg::OP_STATUS) begin
                        r_status[i] <= dec_st;
                    end else begin
                        r_ctl[i]  <= new_ctl;
                        r_init[i] <= new_init;
                        r_sp[i]   <= new_sp;
                    end
                end
            end
        end
    end

endmodule

// ===== hdl/sism_queue.sv =====
`timescale 1ns / 1ps
// Small FIFO of command descriptors between front and back end.
// Depends on sism_pkg.
module sism_queue #(
    parameter int DEPTH = sism_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  sism_pkg::t_cmd i_data,
    output logic           o_full,
    input  logic           i_pop,
    output sism_pkg::t_cmd o_data,
    output logic           o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    sism_pkg::t_cmd   r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count,  n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & ~o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ===== hdl/sism_back.sv =====
`timescale 1ns / 1ps
// Back end: expands queued descriptors into one or two frames and holds the
// output register. Depends on sism_pkg, sism_out_if.
module sism_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  sism_pkg::t_cmd i_cmd,
    input  logic           i_empty,
    output logic           o_pop,
    sism_out_if.source     o_frame
);

    typedef enum logic [1:0] {
        S_FIRST  = 2'b01,
        S_SECOND = 2'b10
    } t_back_state;

    t_back_state                r_state, n_state;
    logic                       r_valid, n_valid;
    logic [sism_pkg::MOTOR_W-1:0] r_motor, n_motor;
    logic [sism_pkg::CTL_W-1:0] r_ctl,   n_ctl;
    sism_pkg::t_setpoints       r_sp,    n_sp;
    logic                       r_last,  n_last;
    logic                       load_ok;

    // output register free, or emptied this cycle
    assign load_ok = ~r_valid | o_frame.ready;

    always_comb begin
        n_state = r_state;
        n_valid = r_valid;
        n_motor = r_motor;
        n_ctl   = r_ctl;
        n_sp    = r_sp;
        n_last  = r_last;
        o_pop   = 1'b0;
        if (load_ok) begin
            n_valid = ~i_empty;
            if (!i_empty) begin
                n_motor = i_cmd.motor;
                n_sp    = i_cmd.sp;
                case (r_state)
                    S_FIRST: begin
                        n_ctl  = i_cmd.ctl_a;
                        n_last = ~i_cmd.two;
                        if (i_cmd.two) begin
                            n_state = S_SECOND;
                        end else begin
                            o_pop = 1'b1;
                        end
                    end
                    S_SECOND: begin
                        n_ctl   = i_cmd.ctl_b;
                        n_last  = 1'b1;
                        n_state = S_FIRST;
                        o_pop   = 1'b1;
                    end
                    default: begin
                        n_state = S_FIRST;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_FIRST;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_motor <= n_motor;
        r_ctl   <= n_ctl;
        r_sp    <= n_sp;
        r_last  <= n_last;
    end

    assign o_frame.valid            = r_valid;
    assign o_frame.out_motor        = r_motor;
    assign o_frame.control_bits     = r_ctl;
    assign o_frame.target_velocity  = r_sp.vel;
    assign o_frame.torque_limit_pos = r_sp.pos;
    assign o_frame.torque_limit_neg = r_sp.neg;
    assign o_frame.last             = r_last;

endmodule

// ===== hdl/inverter_startup_setpoint_manager_top.sv =====
`timescale 1ns / 1ps
// Top level of the inverter startup/setpoint manager.
// Depends on sism_pkg, sism_in_if, sism_out_if, sism_front, sism_queue, sism_back.
//
//  channel   dir  handshake        payload
//  i_cmd     in   valid/ready      opcode, motor, status_byte, velocity_ref, pos/neg torque
//  o_frame   out  valid/ready      out_motor, control_bits, setpoints, last
//  cfg       in   i_cfg_we only    i_cfg_idx, i_cfg_data
//
// An item is taken when i_cmd.valid and i_cmd.ready are both high; state updates
// at that edge. Frames leave the output register one per cycle while o_frame.ready
// is high: a command gives one frame or, in error recovery, two frames. The
// command queue (QUEUE_DEPTH entries) lets input stay open while output stalls.
// Synchronous active-low reset clears all motor state and config; no sweep.
module inverter_startup_setpoint_manager_top #(
    parameter int MOTORS      = sism_pkg::MOTORS_DEF,
    parameter int QUEUE_DEPTH = sism_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    sism_in_if.sink                         i_cmd,
    sism_out_if.source                      o_frame,
    input  logic                            i_cfg_we,
    input  logic [sism_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [sism_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    logic           push, full, pop, empty;
    sism_pkg::t_cmd push_cmd, head_cmd;

    sism_front #(
        .MOTORS (MOTORS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (i_cmd),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_full     (full),
        .o_push     (push),
        .o_cmd      (push_cmd)
    );

    sism_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_data  (head_cmd),
        .o_empty (empty)
    );

    sism_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (head_cmd),
        .i_empty (empty),
        .o_pop   (pop),
        .o_frame (o_frame)
    );

endmodule
